@@ rtl/core/sso_pkg.sv @@
`timescale 1ns / 1ps

package sso_pkg;

  // Field and internal widths.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned DT_W    = 20;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned PM_W    = 48;
  localparam int unsigned QM_W    = 53;
  localparam int unsigned D1_W    = 51;
  localparam int unsigned D1MAG_W = 50;
  localparam int unsigned INC_W   = 33;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned ACC_W   = 65;
  localparam int unsigned SUM_W   = 97;

  // Bandwidth after reset: 100.0 rad/s in Q16.16.
  localparam logic [DATA_W-1:0] BANDWIDTH_RESET = 32'd6553600;

  // Step time rules in microseconds.
  localparam logic [TIME_W-1:0] LONG_GAP_US     = 64'd1000000;
  localparam logic [DT_W-1:0]   DEFAULT_STEP_US = 20'd10000;

  // The step time is dt * 2^31 / 10^6 rounded, rewritten as
  // dt * 2147 + floor((dt * 7557 + 7812) / 15625).
  localparam logic [11:0] TS_WHOLE = 12'd2147;
  localparam logic [12:0] TS_FRAC  = 13'd7557;
  localparam logic [12:0] TS_BIAS  = 13'd7812;
  localparam logic [14:0] TS_DIV   = 15'd15625;
  localparam logic [19:0] TS_RECIP = 20'd549755;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_ROUND_P,
    ST_MUL_QLO,
    ST_MUL_QHI,
    ST_MUL_DLO,
    ST_MUL_DHI,
    ST_MUL_ILO,
    ST_MUL_IHI,
    ST_INC2,
    ST_UPDATE,
    ST_CLEAR
  } state_t;

  // Operand pairs for the shared 32 x 32 multiplier.
  typedef enum logic [2:0] {
    MUL_HOLD,
    MUL_W_E,
    MUL_W_PLO,
    MUL_W_PHI,
    MUL_D_LO,
    MUL_D_HI,
    MUL_Q_LO,
    MUL_Q_HI
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     prep;
    mul_sel_t mul_sel;
    logic     round_p;
    logic     acc_load_q;
    logic     acc_load_i;
    logic     calc_d1;
    logic     calc_qm;
    logic     calc_inc;
    logic     upd_oe;
    logic     upd_de;
    logic     clear_est;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/sso_step_time.sv @@
`timescale 1ns / 1ps

module sso_step_time (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [sso_pkg::TIME_W-1:0] now,
  output logic [sso_pkg::TS_W-1:0]   ts
);
  import sso_pkg::*;

  logic [TIME_W-1:0] prev_time;
  logic [TIME_W-1:0] dt_raw;
  logic [DT_W-1:0]   dt_sel;
  logic [DT_W-1:0]   dt;
  logic [32:0]       x;
  logic [31:0]       base;
  logic [52:0]       recip_prod;
  logic [DT_W-1:0]   q0;
  logic [32:0]       rem_full;
  logic [14:0]       rem;

  // Elapsed time, replaced by the default step after a long gap.
  assign dt_raw = now - prev_time;
  assign dt_sel = (dt_raw > LONG_GAP_US) ? DEFAULT_STEP_US : dt_raw[DT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
    end else if (load) begin
      prev_time <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dt <= dt_sel;
    end
  end

  // Constant division by 15625 as a reciprocal multiply; the estimate is
  // at most one low, and the remainder check below corrects it.
  assign recip_prod = 53'(x) * 53'(TS_RECIP);
  assign rem_full   = x - 33'(34'(q0) * 34'(TS_DIV));

  // Free-running stages: x and base from dt, then q0, then rem, then ts.
  always_ff @(posedge clk) begin
    x    <= 33'(33'(dt) * 33'(TS_FRAC)) + 33'(TS_BIAS);
    base <= 32'(32'(dt) * 32'(TS_WHOLE));
    q0   <= recip_prod[52:33];
    rem  <= rem_full[14:0];
    ts   <= base + 32'(q0) + 32'(rem >= TS_DIV);
  end

endmodule

@@ rtl/core/sso_dpath.sv @@
`timescale 1ns / 1ps

module sso_dpath (
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                clk,
  input  logic                rst,
  input  logic [127:0]        s_tdata,
  input  logic                s_tuser,
  output logic [63:0]         m_tdata,
  output logic                m_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  sso_pkg::cmd_t       cmd,
  output sso_pkg::status_t    status
);
  import sso_pkg::*;

  // Clip old +/- magnitude to signed 32 bits; the top bit is the clip flag.
  function automatic logic [DATA_W:0] clip_add(input logic [DATA_W-1:0] old,
                                                input logic [INC_W-1:0]  mag,
                                                input logic              neg);
    logic signed [34:0] n;
    logic [DATA_W:0]    r;
    n = neg ? ($signed({{3{old[31]}}, old}) - $signed({2'b00, mag}))
            : ($signed({{3{old[31]}}, old}) + $signed({2'b00, mag}));
    if (n > 35'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (n < -35'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, n[31:0]};
    end
    return r;
  endfunction

  logic [DATA_W-1:0]  bandwidth;
  logic               opcode;
  logic [DATA_W-1:0]  meas;
  logic [DATA_W-1:0]  ctrl_in;
  logic [TIME_W-1:0]  now;
  logic [DATA_W-1:0]  oe;
  logic [DATA_W-1:0]  de;
  logic [DATA_W-1:0]  emag;
  logic               eneg;
  logic [PM_W-1:0]    pm;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc;
  logic [QM_W-1:0]    qm;
  logic [D1MAG_W-1:0] d1mag;
  logic               d1neg;
  logic [INC_W-1:0]   inc;
  logic               sat;
  logic [DATA_W-1:0]  out_oe;
  logic [DATA_W-1:0]  out_de;
  logic               out_sat;
  logic               out_valid;
  logic [TS_W-1:0]    ts;

  logic signed [32:0]   e;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [ACC_W-1:0]     psum;
  logic [SUM_W-1:0]     wsum;
  logic signed [D1_W-1:0] p;
  logic signed [D1_W-1:0] d1;
  logic [D1_W-1:0]      d1_abs;
  logic [DATA_W:0]      oe_clip;
  logic [DATA_W:0]      de_clip;

  sso_step_time u_step_time (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.prep),
    .now  (now),
    .ts   (ts)
  );

  // Bandwidth register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bandwidth <= BANDWIDTH_RESET;
    end else if (cfg_wr_en) begin
      bandwidth <= cfg_wr_data;
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opcode  <= s_tuser;
      meas    <= s_tdata[31:0];
      ctrl_in <= s_tdata[63:32];
      now     <= s_tdata[127:64];
    end
  end

  // Estimation error and its magnitude.
  assign e = $signed({meas[31], meas}) - $signed({oe[31], oe});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      eneg <= e[32];
      emag <= e[32] ? 32'(-e) : 32'(e);
    end
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = bandwidth;
    mul_b = emag;
    case (cmd.mul_sel)
      MUL_W_E:   begin mul_a = bandwidth;               mul_b = emag; end
      MUL_W_PLO: begin mul_a = bandwidth;               mul_b = pm[31:0]; end
      MUL_W_PHI: begin mul_a = bandwidth;               mul_b = 32'(pm[PM_W-1:32]); end
      MUL_D_LO:  begin mul_a = d1mag[31:0];             mul_b = ts; end
      MUL_D_HI:  begin mul_a = 32'(d1mag[D1MAG_W-1:32]); mul_b = ts; end
      MUL_Q_LO:  begin mul_a = qm[31:0];                mul_b = ts; end
      MUL_Q_HI:  begin mul_a = 32'(qm[QM_W-1:32]);      mul_b = ts; end
      default:   begin mul_a = bandwidth;               mul_b = emag; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_HOLD) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // Rounded product pieces and the recombined wide product.
  assign psum = ACC_W'(prod) + (ACC_W'(1) << 15);
  assign wsum = SUM_W'(acc) + SUM_W'({prod, 32'b0});

  always_ff @(posedge clk) begin
    if (cmd.round_p) begin
      pm <= psum[63:16];
    end
    if (cmd.acc_load_q) begin
      acc <= ACC_W'(prod) + (ACC_W'(1) << 15);
    end else if (cmd.acc_load_i) begin
      acc <= ACC_W'(prod) + (ACC_W'(1) << 30);
    end
    // Large gains are held at a level that saturates for any nonzero step.
    if (cmd.calc_qm) begin
      qm <= (|wsum[SUM_W-1:69]) ? '1 : wsum[68:16];
    end
    if (cmd.calc_inc) begin
      inc <= (|wsum[SUM_W-1:64]) ? '1 : wsum[63:31];
    end
  end

  // Output estimate derivative: disturbance + 2p + u.
  assign p      = eneg ? -$signed(D1_W'(pm)) : $signed(D1_W'(pm));
  assign d1     = $signed({{(D1_W-DATA_W){de[31]}}, de}) + (p <<< 1)
                + $signed({{(D1_W-DATA_W){ctrl_in[31]}}, ctrl_in});
  assign d1_abs = d1[D1_W-1] ? D1_W'(-d1) : D1_W'(d1);

  always_ff @(posedge clk) begin
    if (cmd.calc_d1) begin
      d1neg <= d1[D1_W-1];
      d1mag <= d1_abs[D1MAG_W-1:0];
    end
  end

  // Estimate updates with saturation.
  assign oe_clip = clip_add(oe, inc, d1neg);
  assign de_clip = clip_add(de, inc, eneg);

  always_ff @(posedge clk) begin
    if (rst) begin
      oe <= '0;
      de <= '0;
    end else if (cmd.clear_est) begin
      oe <= '0;
      de <= '0;
    end else begin
      if (cmd.upd_oe) begin
        oe <= oe_clip[31:0];
      end
      if (cmd.upd_de) begin
        de <= de_clip[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_oe) begin
      sat <= oe_clip[DATA_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.clear_est) begin
      out_oe  <= '0;
      out_de  <= '0;
      out_sat <= 1'b0;
    end else if (cmd.upd_de) begin
      out_oe  <= oe;
      out_de  <= de_clip[31:0];
      out_sat <= sat | de_clip[DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.clear_est || cmd.upd_de) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tdata  = {out_de, out_oe};
  assign m_tuser  = out_sat;
  assign m_tvalid = out_valid;

  assign status.opcode   = opcode;
  assign status.out_free = !out_valid || m_tready;

endmodule

@@ rtl/core/sso_ctrl.sv @@
`timescale 1ns / 1ps

module sso_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sso_pkg::status_t    status,
  output sso_pkg::cmd_t       cmd
);
  import sso_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_PREP;
      ST_PREP:    state_next = status.opcode ? ST_CLEAR : ST_MUL_P;
      ST_MUL_P:   state_next = ST_ROUND_P;
      ST_ROUND_P: state_next = ST_MUL_QLO;
      ST_MUL_QLO: state_next = ST_MUL_QHI;
      ST_MUL_QHI: state_next = ST_MUL_DLO;
      ST_MUL_DLO: state_next = ST_MUL_DHI;
      ST_MUL_DHI: state_next = ST_MUL_ILO;
      ST_MUL_ILO: state_next = ST_MUL_IHI;
      ST_MUL_IHI: state_next = ST_INC2;
      ST_INC2:    state_next = ST_UPDATE;
      ST_UPDATE:  if (status.out_free) state_next = ST_IDLE;
      ST_CLEAR:   if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_HOLD;
    s_tready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_PREP:    cmd.prep = !status.opcode;
      ST_MUL_P:   cmd.mul_sel = MUL_W_E;
      ST_ROUND_P: cmd.round_p = 1'b1;
      ST_MUL_QLO: cmd.mul_sel = MUL_W_PLO;
      ST_MUL_QHI: begin
        cmd.mul_sel    = MUL_W_PHI;
        cmd.acc_load_q = 1'b1;
        cmd.calc_d1    = 1'b1;
      end
      ST_MUL_DLO: begin
        cmd.mul_sel = MUL_D_LO;
        cmd.calc_qm = 1'b1;
      end
      ST_MUL_DHI: begin
        cmd.mul_sel    = MUL_D_HI;
        cmd.acc_load_i = 1'b1;
      end
      ST_MUL_ILO: begin
        cmd.mul_sel  = MUL_Q_LO;
        cmd.calc_inc = 1'b1;
      end
      ST_MUL_IHI: begin
        cmd.mul_sel    = MUL_Q_HI;
        cmd.acc_load_i = 1'b1;
        cmd.upd_oe     = 1'b1;
      end
      ST_INC2:    cmd.calc_inc = 1'b1;
      ST_UPDATE:  cmd.upd_de = status.out_free;
      ST_CLEAR:   cmd.clear_est = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/second_order_state_observer_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Content
// s_        in         s_tvalid / s_tready       update or clear word
// m_        out        m_tvalid / m_tready       estimates and clip flag
// cfg_      in         cfg_wr_en (no wait)       observer bandwidth
//
// An update word passes seven times through the one shared 32 x 32
// multiplier before the block is ready again; a clear word skips it.
// Reset restores the bandwidth to 100 rad/s
// and zeroes both estimates and the stored timestamp. A stalled output
// word holds the finished result; the block waits for the output register
// to free up before it writes the next result.

module second_order_state_observer_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // measured_output [31:0], control_input [63:32], time_now_us [127:64]
  input  logic [127:0] s_tdata,
  // opcode [0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // estimated_output [31:0], estimated_disturbance [63:32]
  output logic [63:0]  m_tdata,
  // saturated [0]
  output logic         m_tuser
);
  import sso_pkg::*;

  cmd_t    cmd;
  status_t status;

  sso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sso_dpath u_dpath (
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

@@ tb/second_order_state_observer_unit_test.sv @@
`timescale 1ns / 1ps

module second_order_state_observer_unit_test;
  import sso_pkg::*;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned RANDOM_PER_SET  = 230;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [63:0] MAG_LIMIT       = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ONE_SECOND_US   = 64'd1000000;
  localparam logic [63:0] FALLBACK_STEP   = 64'd10000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] measured;
    logic [31:0] control;
    logic [63:0] stamp_us;
  } observer_word_t;

  typedef struct packed {
    logic [31:0] est_output;
    logic [31:0] est_disturbance;
    logic        saturated;
  } observer_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [31:0]  cfg_wr_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  second_order_state_observer_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the observer state and its bandwidth register.
  logic [31:0]        bandwidth = BANDWIDTH_RESET;
  logic signed [31:0] output_est = '0;
  logic signed [31:0] disturbance_est = '0;
  logic [63:0]        last_stamp_us = '0;

  observer_word_t   outbound_words[$];
  observer_result_t pending_estimates[$];

  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned clears_sent = 0;
  int unsigned clipped_results = 0;
  int unsigned bandwidth_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned long_holds_requested = 0;
  int unsigned long_holds_done = 0;
  int unsigned hold_cycles = 0;
  logic        word_taken = 1'b0;
  logic [63:0] stim_clock = '0;

  // Rounded (a * b) / 2^sh on the magnitude, limited to 2^62.
  function automatic logic [63:0] scaled_round(logic [63:0] a, logic [63:0] b,
                                               int unsigned sh);
    logic [128:0] prod;
    logic [128:0] quot;
    prod = {65'd0, a} * {65'd0, b};
    prod = prod + (129'd1 << (sh - 1));
    quot = prod >> sh;
    if (quot > {65'd0, MAG_LIMIT}) begin
      return MAG_LIMIT;
    end
    return quot[63:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] clip_q16(longint v, inout logic hit);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      hit = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -longint'(64'h8000_0000)) begin
      hit = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // One Euler step of the observer; a clear word zeroes both estimates.
  function automatic observer_result_t advance_observer(observer_word_t w);
    observer_result_t r;
    logic [63:0] dt;
    logic [63:0] ts;
    logic [63:0] pm;
    logic [63:0] qm;
    logic [63:0] inc1;
    logic [63:0] inc2;
    longint      e;
    longint      p;
    longint      d1;
    longint      n1;
    longint      n2;
    logic        e_neg;
    logic        hit;
    hit = 1'b0;
    if (w.opcode == OP_CLEAR) begin
      output_est = '0;
      disturbance_est = '0;
    end else begin
      dt = w.stamp_us - last_stamp_us;
      last_stamp_us = w.stamp_us;
      if (dt > ONE_SECOND_US) begin
        dt = FALLBACK_STEP;
      end
      ts = (dt * 64'd2147483648 + 64'd500000) / 64'd1000000;
      e = longint'($signed(w.measured)) - longint'(output_est);
      e_neg = (e < 0);
      pm = scaled_round({32'd0, bandwidth}, magnitude(e), 16);
      qm = scaled_round({32'd0, bandwidth}, pm, 16);
      p = e_neg ? -$signed(pm) : $signed(pm);
      d1 = longint'(disturbance_est) + 2 * p + longint'($signed(w.control));
      inc1 = scaled_round(magnitude(d1), ts, 31);
      inc2 = scaled_round(qm, ts, 31);
      n1 = longint'(output_est) + ((d1 < 0) ? -$signed(inc1) : $signed(inc1));
      n2 = longint'(disturbance_est) + (e_neg ? -$signed(inc2) : $signed(inc2));
      output_est = clip_q16(n1, hit);
      disturbance_est = clip_q16(n2, hit);
    end
    r.est_output = output_est;
    r.est_disturbance = disturbance_est;
    r.saturated = hit;
    return r;
  endfunction

  function automatic void queue_word(logic op, logic [31:0] y, logic [31:0] u,
                                     logic [63:0] t);
    observer_word_t w;
    w.opcode = op;
    w.measured = y;
    w.control = u;
    w.stamp_us = t;
    outbound_words.push_back(w);
    words_queued++;
    if (op == OP_CLEAR) begin
      clears_sent++;
    end
  endfunction

  // Mostly small signals, some mid-range, some rails and some raw noise.
  function automatic logic [31:0] random_signal();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
    end else if (pick < 80) begin
      return 32'($urandom_range(32'h2000_0000)) - 32'h1000_0000;
    end else if (pick < 90) begin
      return pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    return $urandom;
  endfunction

  task automatic wait_until_drained();
    while (words_accepted != words_queued || pending_estimates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_bandwidth(logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    bandwidth = value;
    bandwidth_writes++;
  endtask

  // Input side: present the next word once the current one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (outbound_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        observer_word_t w;
        w = outbound_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {w.stamp_us, w.control, w.measured};
        s_tuser <= w.opcode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (long_holds_done < long_holds_requested) begin
      long_holds_done++;
      hold_cycles = LONG_HOLD;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result word against the oldest prediction, then predict for
  // any word accepted at this edge.
  always @(posedge clk) begin : monitor
    observer_result_t got;
    observer_result_t want;
    observer_word_t   taken;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.est_output = m_tdata[31:0];
        got.est_disturbance = m_tdata[63:32];
        got.saturated = m_tuser;
        if (pending_estimates.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Unexpected result word: output %h disturbance %h clipped %b",
                     got.est_output, got.est_disturbance, got.saturated);
          end
        end else begin
          want = pending_estimates.pop_front();
          results_checked++;
          if (want.saturated) begin
            clipped_results++;
          end
          if (got.est_output !== want.est_output ||
              got.est_disturbance !== want.est_disturbance ||
              got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("Result %0d wrong: expected output %h disturbance %h clipped %b,",
                       results_checked, want.est_output, want.est_disturbance,
                       want.saturated);
              $display("  got output %h disturbance %h clipped %b",
                       got.est_output, got.est_disturbance, got.saturated);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        taken.opcode = s_tuser;
        taken.measured = s_tdata[31:0];
        taken.control = s_tdata[63:32];
        taken.stamp_us = s_tdata[127:64];
        pending_estimates.push_back(advance_observer(taken));
        words_accepted++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d results still expected", pending_estimates.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] bw_settings[8];
    int unsigned pick;
    bw_settings[0] = 32'd6553600;
    bw_settings[1] = 32'd65536;
    bw_settings[2] = 32'hFFFF_FFFF;
    bw_settings[3] = 32'($urandom_range(32'h0100_0000, 32'h0001_0000));
    bw_settings[4] = 32'd655360000;
    bw_settings[5] = 32'd1;
    bw_settings[6] = $urandom;
    bw_settings[7] = 32'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset bandwidth: first step after reset, a
    // repeated timestamp, signal rails, time running backward, a gap of
    // exactly one second and just over it, clears and a timestamp wrap.
    queue_word(OP_UPDATE, 32'h0001_0000, 32'h0000_8000, 64'd5000000);
    queue_word(OP_UPDATE, 32'h0002_0000, 32'h0000_0000, 64'd5000000);
    queue_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'd5000500);
    queue_word(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 64'd5001500);
    queue_word(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 64'd4000000);
    queue_word(OP_UPDATE, 32'h0001_0000, 32'h0000_0000, 64'd5000000);
    queue_word(OP_UPDATE, 32'hFFFF_0000, 32'h0001_0000, 64'd6000001);
    queue_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(OP_UPDATE, 32'h0003_0000, 32'hFFFF_FFFF, 64'd999);
    queue_word(OP_CLEAR, 32'h0000_0000, 32'h0000_0000, 64'd0);
    queue_word(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 64'd1999);
    wait_until_drained();

    // Widest bandwidth: drives the estimates into the rails.
    set_bandwidth(32'hFFFF_FFFF);
    queue_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h0000_0000, 64'd3000);
    queue_word(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 64'd13000);
    queue_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 64'd23000);
    queue_word(OP_CLEAR, 32'h0000_0000, 32'h0000_0000, 64'd0);
    queue_word(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 64'd24000);
    wait_until_drained();

    // Zero bandwidth: only the control input moves the output estimate.
    set_bandwidth(32'd0);
    queue_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'd30000);
    queue_word(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 64'd30001);
    queue_word(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 64'd1030001);
    wait_until_drained();
    stim_clock = 64'd1030001;

    // Random control-loop traffic under several bandwidths and flow patterns.
    for (int ph = 0; ph < 8; ph++) begin
      wait_until_drained();
      set_bandwidth(bw_settings[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      if (ph == 4) begin
        long_holds_requested++;
      end
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
        if ($urandom_range(99) < 4) begin
          queue_word(OP_CLEAR, $urandom, $urandom, {$urandom, $urandom});
        end else begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            stim_clock += 64'($urandom_range(2000, 1));
          end else if (pick < 76) begin
            stim_clock = stim_clock;
          end else if (pick < 84) begin
            stim_clock += 64'($urandom_range(1000000, 2000));
          end else if (pick < 88) begin
            stim_clock += pick[0] ? ONE_SECOND_US : ONE_SECOND_US + 64'd1;
          end else if (pick < 94) begin
            stim_clock -= 64'($urandom_range(5000, 1));
          end else begin
            stim_clock = {$urandom, $urandom};
          end
          queue_word(OP_UPDATE, random_signal(), random_signal(), stim_clock);
        end
      end
    end
    wait_until_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d result words from %0d input words (%0d clears, %0d clipped),",
             results_checked, words_accepted, clears_sent, clipped_results);
    $display("across %0d bandwidth writes with idle, stall and back-pressure phases.",
             bandwidth_writes);
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               pending_estimates.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
